// ----- rtl/motor_feedback_turn_tracker_macros.svh -----
// Assertion helpers used by the tracker back end (mftt_back).
`ifndef MOTOR_FEEDBACK_TURN_TRACKER_MACROS_SVH
`define MOTOR_FEEDBACK_TURN_TRACKER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define MFTT_ASSERT_NOW(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("tracker check failed");

// The condition must hold in the cycle after the trigger.
`define MFTT_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("tracker check failed");

`endif

// ----- rtl/mftt_pkg.sv -----
package mftt_pkg;

	localparam int DEF_BUS_COUNT     = 2;
	localparam int DEF_SLOTS_PER_BUS = 12;
	localparam int FIFO_DEPTH        = 4;

	localparam logic [10:0] FIRST_ID = 11'h201;
	localparam int          ENC_TOP  = 8191;

	// ENTRY_IDX_W is wide enough for the largest bus and slot counts; the mask covers only 24 entries.
	localparam int ENTRY_IDX_W = 6;
	localparam int MASK_W      = 24;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_BAND    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOT_LIMIT    = 2'd3;

	localparam logic [23:0] RST_PRESENT_MASK = 24'd0;
	localparam logic [11:0] RST_WRAP_BAND    = 12'd3000;
	localparam logic [14:0] RST_SLOW_LIMIT   = 15'd100;
	localparam logic [7:0]  RST_HOT_LIMIT    = 8'd80;

	// One classified frame waiting for the state update.
	typedef struct packed {
		logic [3:0]             slot;
		logic                   hit;
		logic [ENTRY_IDX_W-1:0] idx;
		logic signed [15:0]     angle;
		logic signed [15:0]     speed;
		logic signed [15:0]     torque;
		logic [7:0]             temperature;
	} mftt_item_t;

endpackage

// ----- rtl/mftt_if.sv -----
interface mftt_in_if;
	logic       valid;
	logic       ready;
	logic       bus;
	logic [10:0] frame_id;
	logic [7:0] byte_0;
	logic [7:0] byte_1;
	logic [7:0] byte_2;
	logic [7:0] byte_3;
	logic [7:0] byte_4;
	logic [7:0] byte_5;
	logic [7:0] byte_6;

	modport source (output valid, bus, frame_id, byte_0, byte_1, byte_2, byte_3, byte_4,
		byte_5, byte_6, input ready);
	modport sink (input valid, bus, frame_id, byte_0, byte_1, byte_2, byte_3, byte_4,
		byte_5, byte_6, output ready);
endinterface

interface mftt_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         slot;
	logic               valid_res;
	logic signed [15:0] angle;
	logic signed [15:0] speed;
	logic signed [15:0] torque;
	logic [7:0]         temperature;
	logic signed [31:0] turn_position;
	logic               overheated;

	modport source (output valid, slot, valid_res, angle, speed, torque, temperature,
		turn_position, overheated, input ready);
	modport sink (input valid, slot, valid_res, angle, speed, torque, temperature,
		turn_position, overheated, output ready);
endinterface

// ----- rtl/mftt_fifo.sv -----
module mftt_fifo
	import mftt_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mftt_item_t push_item,
	output logic       full,
	input  logic       pop,
	output mftt_item_t pop_item,
	output logic       not_empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mftt_item_t       slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/mftt_front.sv -----
module mftt_front
	import mftt_pkg::*;
#(
	parameter int BUS_COUNT     = DEF_BUS_COUNT,
	parameter int SLOTS_PER_BUS = DEF_SLOTS_PER_BUS
) (
	mftt_in_if.sink           feed,
	input  logic [MASK_W-1:0] present_mask,
	input  logic              full,
	output logic              push,
	output mftt_item_t        push_item
);
	localparam int ENTRY_COUNT = BUS_COUNT * SLOTS_PER_BUS;

	logic [10:0]            id_off;
	logic                   in_range;
	logic [3:0]             slot;
	logic [ENTRY_IDX_W-1:0] idx;
	logic                   hit;

	assign feed.ready = !full;
	assign push       = feed.valid && !full;

	always_comb begin
		id_off   = feed.frame_id - FIRST_ID;
		in_range = (feed.frame_id >= FIRST_ID) && (id_off < 11'(SLOTS_PER_BUS));
		slot     = in_range ? id_off[3:0] : 4'd0;
		idx      = feed.bus ? ENTRY_IDX_W'(SLOTS_PER_BUS) + ENTRY_IDX_W'(slot)
			: ENTRY_IDX_W'(slot);
		// A frame counts only for an existing bus and an entry covered by the mask.
		hit = in_range && (32'(feed.bus) < BUS_COUNT)
			&& (idx < ENTRY_IDX_W'(MASK_W)) && (32'(idx) < ENTRY_COUNT)
			&& present_mask[idx[4:0]];

		push_item.slot        = slot;
		push_item.hit         = hit;
		push_item.idx         = idx;
		push_item.angle       = {feed.byte_0, feed.byte_1};
		push_item.speed       = {feed.byte_2, feed.byte_3};
		push_item.torque      = {feed.byte_4, feed.byte_5};
		push_item.temperature = feed.byte_6;
	end

endmodule

// ----- rtl/mftt_back.sv -----
`include "motor_feedback_turn_tracker_macros.svh"

module mftt_back
	import mftt_pkg::*;
#(
	parameter int BUS_COUNT     = DEF_BUS_COUNT,
	parameter int SLOTS_PER_BUS = DEF_SLOTS_PER_BUS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [11:0] wrap_band,
	input  logic [14:0] slow_speed_limit,
	input  logic [7:0]  hot_limit,
	input  logic        not_empty,
	input  mftt_item_t  pop_item,
	output logic        pop,
	mftt_out_if.source  result
);
	localparam int ENTRY_COUNT = BUS_COUNT * SLOTS_PER_BUS;
	localparam int IDX_W       = $clog2(ENTRY_COUNT);

	logic signed [15:0] prev_q [ENTRY_COUNT];
	logic signed [31:0] acc_q  [ENTRY_COUNT];

	logic               out_valid_q;
	logic [3:0]         slot_q;
	logic               hit_q;
	logic signed [15:0] angle_q;
	logic signed [15:0] speed_q;
	logic signed [15:0] torque_q;
	logic [7:0]         temp_q;
	logic signed [31:0] pos_q;
	logic               hot_q;

	logic [IDX_W-1:0]   ix;
	logic signed [15:0] last;
	logic signed [16:0] ang17;
	logic signed [16:0] last17;
	logic signed [16:0] band17;
	logic signed [16:0] hi_thr;
	logic signed [16:0] d;
	logic [16:0]        mag;
	logic               slow;
	logic signed [17:0] d18;
	logic signed [17:0] add;
	logic signed [31:0] acc_new;
	logic               upd;

	assign pop = not_empty && (!out_valid_q || result.ready);
	assign upd = pop && pop_item.hit;

	always_comb begin
		ix     = pop_item.idx[IDX_W-1:0];
		last   = prev_q[ix];
		ang17  = {pop_item.angle[15], pop_item.angle};
		last17 = {last[15], last};
		band17 = {5'b0, wrap_band};
		hi_thr = 17'(ENC_TOP) - band17;
		d      = ang17 - last17;
		d18    = {d[16], d};
		mag    = pop_item.speed[15] ? 17'(-{pop_item.speed[15], pop_item.speed})
			: {1'b0, pop_item.speed};
		slow   = mag < {2'b0, slow_speed_limit};
		add    = d18;
		if (slow) begin
			// Position based: a jump across the band near the ends is a wrap.
			if (ang17 > hi_thr && last17 < band17) begin
				add = d18 - 18'(ENC_TOP);
			end else if (ang17 < band17 && last17 > hi_thr) begin
				add = d18 + 18'(ENC_TOP);
			end
		end else begin
			// Direction based: a step against the sign of the speed is a wrap.
			if (pop_item.speed < 0 && d > 0) begin
				add = d18 - 18'(ENC_TOP);
			end else if (pop_item.speed > 0 && d < 0) begin
				add = d18 + 18'(ENC_TOP);
			end
		end
		acc_new = acc_q[ix] + {{14{add[17]}}, add};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				prev_q[i] <= '0;
				acc_q[i]  <= '0;
			end
		end else if (upd) begin
			prev_q[ix] <= pop_item.angle;
			acc_q[ix]  <= acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			slot_q   <= pop_item.slot;
			hit_q    <= pop_item.hit;
			angle_q  <= pop_item.angle;
			speed_q  <= pop_item.speed;
			torque_q <= pop_item.torque;
			temp_q   <= pop_item.temperature;
			pos_q    <= pop_item.hit ? acc_new : '0;
			hot_q    <= pop_item.hit && (pop_item.temperature > hot_limit);
		end
	end

	assign result.valid         = out_valid_q;
	assign result.slot          = slot_q;
	assign result.valid_res     = hit_q;
	assign result.angle         = angle_q;
	assign result.speed         = speed_q;
	assign result.torque        = torque_q;
	assign result.temperature   = temp_q;
	assign result.turn_position = pos_q;
	assign result.overheated    = hot_q;

	`MFTT_ASSERT_NOW(a_pos_zero_on_miss, clk, arst_n, out_valid_q && !hit_q, pos_q == '0)
	`MFTT_ASSERT_NOW(a_hot_needs_hit, clk, arst_n, out_valid_q && hot_q, hit_q)
	`MFTT_ASSERT_NEXT(a_pop_fills_output, clk, arst_n, pop, out_valid_q)
	`MFTT_ASSERT_NEXT(a_prev_follows_angle, clk, arst_n, upd, prev_q[$past(ix)] == $past(pop_item.angle))

endmodule

// ----- rtl/motor_feedback_turn_tracker.sv -----
// Channel | Role   | Payload
// feed    | sink   | bus, frame_id, byte_0 .. byte_6 (one feedback frame)
// result  | source | slot, valid_res, angle, speed, torque, temperature, turn_position,
//         |        | overheated
// A frame is classified in the cycle of its transfer and enters a four-entry queue.
// The back end takes one frame a cycle from the queue while the output register is free or
// being read, updates the slot state in the same cycle and shows the result in the next cycle.
// Sustained rate is one frame per cycle while result is not stalled.
// Reset clears all slot state at once and restores the register defaults.
// A stall on result fills the queue; feed.ready drops only when the queue is full.
module motor_feedback_turn_tracker
	import mftt_pkg::*;
#(
	parameter int BUS_COUNT     = DEF_BUS_COUNT,
	parameter int SLOTS_PER_BUS = DEF_SLOTS_PER_BUS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mftt_in_if.sink               feed,
	mftt_out_if.source            result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);
	logic [MASK_W-1:0] present_mask_q;
	logic [11:0]       wrap_band_q;
	logic [14:0]       slow_limit_q;
	logic [7:0]        hot_limit_q;

	logic       push;
	mftt_item_t push_item;
	logic       full;
	logic       pop;
	mftt_item_t pop_item;
	logic       not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_mask_q <= RST_PRESENT_MASK;
			wrap_band_q    <= RST_WRAP_BAND;
			slow_limit_q   <= RST_SLOW_LIMIT;
			hot_limit_q    <= RST_HOT_LIMIT;
		end else if (wr_en) begin
			case (wr_index)
				REG_PRESENT_MASK: present_mask_q <= wr_data[23:0];
				REG_WRAP_BAND:    wrap_band_q    <= wr_data[11:0];
				REG_SLOW_LIMIT:   slow_limit_q   <= wr_data[14:0];
				REG_HOT_LIMIT:    hot_limit_q    <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	mftt_front #(
		.BUS_COUNT     (BUS_COUNT),
		.SLOTS_PER_BUS (SLOTS_PER_BUS)
	) u_front (
		.feed         (feed),
		.present_mask (present_mask_q),
		.full         (full),
		.push         (push),
		.push_item    (push_item)
	);

	mftt_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (not_empty)
	);

	mftt_back #(
		.BUS_COUNT     (BUS_COUNT),
		.SLOTS_PER_BUS (SLOTS_PER_BUS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.wrap_band        (wrap_band_q),
		.slow_speed_limit (slow_limit_q),
		.hot_limit        (hot_limit_q),
		.not_empty        (not_empty),
		.pop_item         (pop_item),
		.pop              (pop),
		.result           (result)
	);

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import mftt_pkg::*;

	localparam int SLOTS       = DEF_SLOTS_PER_BUS;
	localparam int ENTRIES     = DEF_BUS_COUNT * DEF_SLOTS_PER_BUS;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 64;

	typedef struct packed {
		logic             bus;
		logic [10:0]      frame_id;
		logic [0:6][7:0]  data;
	} frame_t;

	typedef struct packed {
		logic [3:0]         slot;
		logic               valid_res;
		logic signed [15:0] angle;
		logic signed [15:0] speed;
		logic signed [15:0] torque;
		logic [7:0]         temperature;
		logic signed [31:0] turn_position;
		logic               overheated;
	} feedback_report_t;

	class turn_scoreboard;
		logic [23:0]        present;
		logic [11:0]        band;
		logic [14:0]        slow_limit;
		logic [7:0]         hot_limit;
		logic signed [15:0] last_angle [ENTRIES];
		logic [31:0]        turn_acc [ENTRIES];
		feedback_report_t   pending_reports [$];
		int                 mismatches;

		function new();
			present    = RST_PRESENT_MASK;
			band       = RST_WRAP_BAND;
			slow_limit = RST_SLOW_LIMIT;
			hot_limit  = RST_HOT_LIMIT;
			mismatches = 0;
			foreach (last_angle[i]) begin
				last_angle[i] = '0;
				turn_acc[i]   = '0;
			end
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_PRESENT_MASK: present    = data[23:0];
				REG_WRAP_BAND:    band       = data[11:0];
				REG_SLOW_LIMIT:   slow_limit = data[14:0];
				REG_HOT_LIMIT:    hot_limit  = data[7:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_reports.size();
		endfunction

		// Works out the report for one accepted frame and moves the slot state on.
		function void note_frame(frame_t f);
			feedback_report_t r;
			int id_off, entry, ang, spd, last, delta, step, mag, edge_band;
			r = '0;
			r.angle       = {f.data[0], f.data[1]};
			r.speed       = {f.data[2], f.data[3]};
			r.torque      = {f.data[4], f.data[5]};
			r.temperature = f.data[6];
			id_off = int'(f.frame_id) - int'(FIRST_ID);
			if (id_off >= 0 && id_off < SLOTS) begin
				r.slot = id_off[3:0];
				entry  = int'(f.bus) * SLOTS + id_off;
				if (present[entry]) begin
					ang       = int'(r.angle);
					spd       = int'(r.speed);
					last      = int'(last_angle[entry]);
					delta     = ang - last;
					edge_band = int'(band);
					mag       = spd < 0 ? -spd : spd;
					if (mag < int'(slow_limit)) begin
						// Slow: a jump from one end band to the other is a wrap.
						if (ang > ENC_TOP - edge_band && last < edge_band)
							step = delta - ENC_TOP;
						else if (ang < edge_band && last > ENC_TOP - edge_band)
							step = delta + ENC_TOP;
						else
							step = delta;
					end else begin
						// Fast: a step against the direction of rotation is a wrap.
						if (spd < 0 && delta > 0)
							step = delta - ENC_TOP;
						else if (spd > 0 && delta < 0)
							step = delta + ENC_TOP;
						else
							step = delta;
					end
					turn_acc[entry]   = turn_acc[entry] + 32'(step);
					last_angle[entry] = r.angle;
					r.valid_res       = 1'b1;
					r.turn_position   = turn_acc[entry];
					r.overheated      = r.temperature > hot_limit;
				end
			end
			pending_reports.push_back(r);
		endfunction

		task report(string what, longint got, longint want);
			mismatches++;
			$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		endtask

		task check_report(feedback_report_t got);
			feedback_report_t want;
			if (pending_reports.size() == 0) begin
				report("unexpected result, turn_position", got.turn_position, 0);
				return;
			end
			want = pending_reports.pop_front();
			if (got.slot !== want.slot)
				report("slot", got.slot, want.slot);
			if (got.valid_res !== want.valid_res)
				report("valid_res", got.valid_res, want.valid_res);
			if (got.angle !== want.angle)
				report("angle", got.angle, want.angle);
			if (got.speed !== want.speed)
				report("speed", got.speed, want.speed);
			if (got.torque !== want.torque)
				report("torque", got.torque, want.torque);
			if (got.temperature !== want.temperature)
				report("temperature", got.temperature, want.temperature);
			if (got.turn_position !== want.turn_position)
				report("turn_position", got.turn_position, want.turn_position);
			if (got.overheated !== want.overheated)
				report("overheated", got.overheated, want.overheated);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	int             send_idle_pct = 6;
	int             recv_idle_pct = 49;
	bit             hold_request  = 1'b0;
	int             quiet_cycles  = 0;
	turn_scoreboard tracker;

	mftt_in_if  feed ();
	mftt_out_if result ();

	motor_feedback_turn_tracker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stalls, plus one long hold-off on request so the queue fills.
	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			result.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			tracker.check_report(feedback_report_t'({result.slot, result.valid_res,
				result.angle, result.speed, result.torque, result.temperature,
				result.turn_position, result.overheated}));
	end

	always @(posedge clk) begin
		if (!arst_n || (feed.valid && feed.ready) || (result.valid && result.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic frame_t frame_of(bit b, int id, int ang, int spd, int trq, int temp);
		frame_t f;
		f.bus      = b;
		f.frame_id = 11'(id);
		f.data     = {16'(ang), 16'(spd), 16'(trq), 8'(temp)};
		return f;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_frame(frame_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			feed.valid <= 1'b0;
			@(negedge clk);
		end
		feed.valid    <= 1'b1;
		feed.bus      <= f.bus;
		feed.frame_id <= f.frame_id;
		feed.byte_0   <= f.data[0];
		feed.byte_1   <= f.data[1];
		feed.byte_2   <= f.data[2];
		feed.byte_3   <= f.data[3];
		feed.byte_4   <= f.data[4];
		feed.byte_5   <= f.data[5];
		feed.byte_6   <= f.data[6];
		do
			@(posedge clk);
		while (!feed.ready);
		tracker.note_frame(f);
		@(negedge clk);
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic settle();
		feed.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_settings(logic [23:0] mask, logic [11:0] band, logic [14:0] slow,
			logic [7:0] hot);
		logic [CFG_DATA_W-1:0] value [4];
		value[REG_PRESENT_MASK] = CFG_DATA_W'(mask);
		value[REG_WRAP_BAND]    = CFG_DATA_W'(band);
		value[REG_SLOW_LIMIT]   = CFG_DATA_W'(slow);
		value[REG_HOT_LIMIT]    = CFG_DATA_W'(hot);
		for (int i = 0; i < 4; i++) begin
			wr_en    <= 1'b1;
			wr_index <= CFG_IDX_W'(i);
			wr_data  <= value[i];
			tracker.write_register(CFG_IDX_W'(i), value[i]);
			@(negedge clk);
		end
		wr_en <= 1'b0;
	endtask

	// Mostly frames for real slots, half of them with angles near the ends of the encoder range;
	// the rest are raw bytes and stray identifiers.
	task automatic random_run(int wanted);
		frame_t f;
		int kind, ang, spd;
		for (int n = 0; n < wanted; n++) begin
			f.bus = 1'($urandom_range(1));
			kind  = $urandom_range(99);
			if (kind < 12)
				f.frame_id = 11'($urandom_range(2047));
			else
				f.frame_id = 11'(int'(FIRST_ID) + $urandom_range(SLOTS - 1));
			if (kind < 20) begin
				f.data = {24'($urandom), 32'($urandom)};
			end else begin
				case ($urandom_range(3))
					0: ang = $urandom_range(int'(tracker.band));
					1: ang = ENC_TOP - int'($urandom_range(int'(tracker.band)));
					default: ang = $urandom_range(ENC_TOP);
				endcase
				if ($urandom_range(1))
					spd = int'($urandom_range(2 * int'(tracker.slow_limit)))
						- int'(tracker.slow_limit);
				else
					spd = $urandom_range(65535);
				f.data = {16'(ang), 16'(spd), 16'($urandom), 8'($urandom)};
			end
			send_frame(f);
		end
	endtask

	initial begin
		tracker       = new();
		arst_n        = 1'b0;
		wr_en         = 1'b0;
		wr_index      = '0;
		wr_data       = '0;
		feed.valid    = 1'b0;
		feed.bus      = 1'b0;
		feed.frame_id = '0;
		feed.byte_0   = '0;
		feed.byte_1   = '0;
		feed.byte_2   = '0;
		feed.byte_3   = '0;
		feed.byte_4   = '0;
		feed.byte_5   = '0;
		feed.byte_6   = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Nothing is present after reset.
		send_frame(frame_of(1'b0, 'h201, 100, 0, 0, 20));
		settle();
		apply_settings(24'hFFFFFF, 12'd3000, 15'd100, 8'd80);

		// Identifiers just outside the slot range and at the ends of the field.
		send_frame(frame_of(1'b0, 'h200, 500, 0, 0, 90));
		send_frame(frame_of(1'b1, 'h20D, 500, 0, 0, 90));
		send_frame(frame_of(1'b0, 'h000, 0, 0, 0, 0));
		send_frame(frame_of(1'b1, 'h7FF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFF));
		// Slow wraps in both directions, then a plain slow step.
		send_frame(frame_of(1'b0, 'h201, 8000, 0, 10, 30));
		send_frame(frame_of(1'b0, 'h201, 100, 5, 10, 30));
		send_frame(frame_of(1'b0, 'h201, 4000, 50, 10, 30));
		// Fast: with and against the speed, and a zero step.
		send_frame(frame_of(1'b0, 'h201, 3000, -500, 10, 30));
		send_frame(frame_of(1'b0, 'h201, 3500, -500, 10, 30));
		send_frame(frame_of(1'b0, 'h201, 3400, 500, 10, 30));
		send_frame(frame_of(1'b0, 'h201, 3400, 500, 10, 30));
		// Speed magnitude equal to the limit is fast, one below is slow.
		send_frame(frame_of(1'b0, 'h201, 3500, -100, 10, 30));
		send_frame(frame_of(1'b0, 'h201, 3300, 99, 10, 30));
		// Angles outside the encoder range and extreme speed, torque and temperature.
		send_frame(frame_of(1'b0, 'h201, 'hFFFF, 0, 0, 81));
		send_frame(frame_of(1'b0, 'h201, 'h7FFF, 'h8000, 0, 80));
		send_frame(frame_of(1'b0, 'h201, 'h8000, 'h7FFF, 'h8000, 255));
		send_frame(frame_of(1'b0, 'h201, 0, 0, 'h7FFF, 0));
		// Last slot of the second bus, and the slots either side of the bus boundary.
		send_frame(frame_of(1'b1, 'h20C, 8191, 0, 0, 40));
		send_frame(frame_of(1'b1, 'h20C, 0, 0, 0, 40));
		send_frame(frame_of(1'b0, 'h20C, 6000, 200, 0, 40));
		send_frame(frame_of(1'b1, 'h201, 200, -200, 0, 40));
		settle();

		apply_settings(24'($urandom) | 24'($urandom), 12'd4095, 15'd32767, 8'd0);
		hold_request = 1'b1;
		random_run(220);
		settle();

		send_idle_pct = 49;
		recv_idle_pct = 6;
		apply_settings(24'hFFFFFF, 12'd0, 15'd0, 8'd255);
		random_run(220);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_settings(24'($urandom) | 24'($urandom), 12'($urandom),
			15'($urandom_range(2000)), 8'($urandom));
		random_run(210);
		settle();
		repeat (8) @(posedge clk);

		if (tracker.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
